### hdl/hscu_pkg.sv
// Shared types, codes and tables of the Hybla-style window update engine.
`default_nettype none
package hscu_pkg;

	localparam int WIN_W   = 32;
	localparam int RTT_W   = 24;
	localparam int REF_W   = 10;
	localparam int CLAMP_W = 16;
	localparam int SSTH_W  = 31;
	localparam int NWIN_W  = 16;
	localparam int RHOI_W  = 21;
	localparam int CRED_W  = 7;
	localparam int DIV_W   = 32;
	localparam int DIV_CNT_W = 6;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_REF_RTT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLAMP   = 1'b1;

	localparam logic [REF_W-1:0]   REF_RTT_RST = 10'd5;
	localparam logic [CLAMP_W-1:0] CLAMP_MAX   = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_ACK   = 2'd0,
		OP_INIT  = 2'd1,
		OP_STATE = 2'd2,
		OP_WIN   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_RHO_WAIT,
		S_INIT_APPLY,
		S_ACK_CHECK,
		S_ACK_INC,
		S_INC_WAIT,
		S_ADD,
		S_CARRY,
		S_STALL,
		S_CLAMP_SS,
		S_CLAMP_WIN,
		S_LOSS1,
		S_LOSS2,
		S_OUT
	} state_t;

	typedef enum logic [4:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_RHO_SET,
		ACT_INIT,
		ACT_STATE,
		ACT_WIN,
		ACT_DEFER,
		ACT_SLOW_INC,
		ACT_DIV_INC,
		ACT_ADD,
		ACT_CARRY,
		ACT_STALL,
		ACT_CLAMP_SS,
		ACT_CLAMP_WIN,
		ACT_LOSS1,
		ACT_LOSS2,
		ACT_OUT
	} act_t;

	typedef enum logic {
		DIV_RHO,
		DIV_INC
	} div_sel_t;

	typedef struct packed {
		act_t     act;
		logic     div_start;
		div_sel_t div_sel;
		logic     upd_min;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic rtt_lt_min;
		logic limited;
		logic enhanced;
		logic rho_zero;
		logic slow;
		logic div_done;
		logic out_free;
	} stat_t;

	// 2^(f/8) in 1/128 units
	function automatic logic [7:0] pow2_eighth(input logic [2:0] f);
		logic [7:0] v;
		unique case (f)
			3'd0: v = 8'd128;
			3'd1: v = 8'd139;
			3'd2: v = 8'd152;
			3'd3: v = 8'd165;
			3'd4: v = 8'd181;
			3'd5: v = 8'd197;
			3'd6: v = 8'd215;
			3'd7: v = 8'd234;
			default: v = 8'd128;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### hdl/hscu_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module hscu_div
	import hscu_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DIV_W-1:0] divisor,
	output logic                  done,
	output logic [DIV_W-1:0]      quotient
);

	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_W:0]       shifted;
	logic [DIV_W:0]       diff;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DIV_W]) begin
				rem_q <= diff[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule
`default_nettype wire

### hdl/hscu_ctrl.sv
// Sequencer of the window update engine.
`default_nettype none
module hscu_ctrl
	import hscu_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t state_q, state_d;
	state_t ret_q, ret_d;

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				unique case (stat.op)
					OP_ACK: begin
						if (stat.rtt_lt_min) begin
							ret_d   = S_ACK_CHECK;
							state_d = S_RHO_WAIT;
						end else begin
							state_d = S_ACK_CHECK;
						end
					end
					OP_INIT: begin
						ret_d   = S_INIT_APPLY;
						state_d = S_RHO_WAIT;
					end
					OP_STATE: state_d = S_LOSS1;
					OP_WIN:   state_d = S_LOSS1;
					default:  state_d = S_LOSS1;
				endcase
			end
			S_RHO_WAIT: begin
				if (stat.div_done) state_d = ret_q;
			end
			S_INIT_APPLY: state_d = S_LOSS1;
			S_ACK_CHECK: begin
				if (!stat.limited || !stat.enhanced) begin
					state_d = S_LOSS1;
				end else if (stat.rho_zero) begin
					ret_d   = S_ACK_INC;
					state_d = S_RHO_WAIT;
				end else begin
					state_d = S_ACK_INC;
				end
			end
			S_ACK_INC: begin
				if (stat.slow) state_d = S_ADD;
				else           state_d = S_INC_WAIT;
			end
			S_INC_WAIT: begin
				if (stat.div_done) state_d = S_ADD;
			end
			S_ADD:       state_d = S_CARRY;
			S_CARRY:     state_d = S_STALL;
			S_STALL:     state_d = S_CLAMP_SS;
			S_CLAMP_SS:  state_d = S_CLAMP_WIN;
			S_CLAMP_WIN: state_d = S_LOSS1;
			S_LOSS1:     state_d = S_LOSS2;
			S_LOSS2:     state_d = S_OUT;
			S_OUT: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd.act       = ACT_NONE;
		cmd.div_start = 1'b0;
		cmd.div_sel   = DIV_RHO;
		cmd.upd_min   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) cmd.act = ACT_LOAD;
			end
			S_DECODE: begin
				unique case (stat.op)
					OP_ACK: begin
						if (stat.rtt_lt_min) begin
							cmd.upd_min   = 1'b1;
							cmd.div_start = 1'b1;
						end
					end
					OP_INIT: begin
						cmd.upd_min   = 1'b1;
						cmd.div_start = 1'b1;
					end
					OP_STATE: cmd.act = ACT_STATE;
					OP_WIN:   cmd.act = ACT_WIN;
					default:  cmd.act = ACT_NONE;
				endcase
			end
			S_RHO_WAIT: begin
				if (stat.div_done) cmd.act = ACT_RHO_SET;
			end
			S_INIT_APPLY: cmd.act = ACT_INIT;
			S_ACK_CHECK: begin
				if (!stat.limited) begin
					cmd.act = ACT_NONE;
				end else if (!stat.enhanced) begin
					cmd.act = ACT_DEFER;
				end else if (stat.rho_zero) begin
					cmd.div_start = 1'b1;
				end
			end
			S_ACK_INC: begin
				if (stat.slow) begin
					cmd.act = ACT_SLOW_INC;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_INC;
				end
			end
			S_INC_WAIT: begin
				if (stat.div_done) cmd.act = ACT_DIV_INC;
			end
			S_ADD:       cmd.act = ACT_ADD;
			S_CARRY:     cmd.act = ACT_CARRY;
			S_STALL:     cmd.act = ACT_STALL;
			S_CLAMP_SS:  cmd.act = ACT_CLAMP_SS;
			S_CLAMP_WIN: cmd.act = ACT_CLAMP_WIN;
			S_LOSS1:     cmd.act = ACT_LOSS1;
			S_LOSS2:     cmd.act = ACT_LOSS2;
			S_OUT: begin
				if (stat.out_free) cmd.act = ACT_OUT;
			end
			default: cmd.act = ACT_NONE;
		endcase
	end

endmodule
`default_nettype wire

### hdl/hscu_dp.sv
// Datapath of the window update engine: state registers, arithmetic, result register.
`default_nettype none
module hscu_dp
	import hscu_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	output stat_t                     stat,
	input  wire logic [1:0]           op,
	input  wire logic [RTT_W-1:0]     smoothed_rtt,
	input  wire logic                 window_limited,
	input  wire logic                 state_open,
	input  wire logic [SSTH_W-1:0]    slow_start_threshold,
	input  wire logic [NWIN_W-1:0]    new_window,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [WIN_W-1:0]          window,
	output logic [WIN_W-1:0]          loss_threshold,
	output logic                      deferred,
	output logic [RHOI_W-1:0]         rho_integer
);

	// captured request
	logic [1:0]        op_q;
	logic [RTT_W-1:0]  rtt_q;
	logic              limited_q;
	logic              open_q;
	logic [SSTH_W-1:0] ssth_q;
	logic [NWIN_W-1:0] nwin_q;

	// configuration
	logic [REF_W-1:0]   ref_q;
	logic [CLAMP_W-1:0] clamp_q;

	// algorithm state
	logic [WIN_W-1:0]  cwnd_q;
	logic [CRED_W-1:0] credit_q;
	logic [WIN_W-1:0]  stall_q;
	logic [RTT_W-1:0]  rho8_q;
	logic [RHOI_W-1:0] rhoi_q;
	logic [WIN_W-1:0]  rho_sq_q;
	logic [RTT_W-1:0]  min_q;
	logic              enh_q;

	// per-request scratch
	logic [WIN_W-1:0] inc_q;
	logic             slow_q;
	logic             carry_q;
	logic             defer_q;
	logic [WIN_W-1:0] loss_part_q;
	logic [WIN_W-1:0] loss_q;

	// result register
	logic              out_valid_q;
	logic [WIN_W-1:0]  out_win_q;
	logic [WIN_W-1:0]  out_loss_q;
	logic              out_def_q;
	logic [RHOI_W-1:0] out_rhoi_q;

	logic [DIV_W-1:0]   div_dividend;
	logic [DIV_W-1:0]   div_divisor;
	logic               div_done;
	logic [DIV_W-1:0]   div_quo;
	logic [RTT_W-1:0]   rho_new;
	logic [2*RTT_W-1:0] rho_prod;
	logic [4:0]         slow_sh;
	logic [WIN_W-1:0]   slow_inc;
	logic [CRED_W:0]    credit_sum;
	logic [WIN_W-1:0]   loss_sum;
	logic               out_free;

	always_comb begin
		if (cmd.div_sel == DIV_RHO) begin
			div_dividend = {{(DIV_W-RTT_W){1'b0}}, rtt_q};
			div_divisor  = (ref_q == '0) ? DIV_W'(1) : {{(DIV_W-REF_W){1'b0}}, ref_q};
		end else begin
			div_dividend = rho_sq_q;
			div_divisor  = (cwnd_q == '0) ? DIV_W'(1) : cwnd_q;
		end
	end

	hscu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// rho floors at one (eight eighths); the quotient never exceeds the RTT width
	assign rho_new  = (div_quo[RTT_W-1:0] < RTT_W'(8)) ? RTT_W'(8) : div_quo[RTT_W-1:0];
	assign rho_prod = rho_new * rho_new;

	// 2^rho - 1 in 1/128 units, integer part capped at sixteen
	assign slow_sh  = (rhoi_q < RHOI_W'(16)) ? rhoi_q[4:0] : 5'd16;
	assign slow_inc = ({{(WIN_W-8){1'b0}}, pow2_eighth(rho8_q[2:0])} << slow_sh)
		- WIN_W'(128);

	assign credit_sum = {1'b0, credit_q} + {1'b0, inc_q[CRED_W-1:0]};
	assign loss_sum   = loss_part_q + (cwnd_q >> 3) + (cwnd_q >> 5);
	assign out_free   = !out_valid_q || !out_stall;

	always_comb begin
		stat.op         = op_t'(op_q);
		stat.rtt_lt_min = (rtt_q < min_q);
		stat.limited    = limited_q;
		stat.enhanced   = enh_q;
		stat.rho_zero   = (rhoi_q == '0);
		stat.slow       = (cwnd_q < {1'b0, ssth_q});
		stat.div_done   = div_done;
		stat.out_free   = out_free;
	end

	// request capture and scratch, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.act == ACT_LOAD) begin
			op_q      <= op;
			rtt_q     <= smoothed_rtt;
			limited_q <= window_limited;
			open_q    <= state_open;
			ssth_q    <= slow_start_threshold;
			nwin_q    <= new_window;
		end
		if (cmd.act == ACT_LOSS1)
			loss_part_q <= cwnd_q - (cwnd_q >> 1) + (cwnd_q >> 2);
		if (cmd.act == ACT_LOSS2)
			loss_q <= (loss_sum < WIN_W'(2)) ? WIN_W'(2) : loss_sum;
		if (cmd.act == ACT_OUT) begin
			out_win_q  <= cwnd_q;
			out_loss_q <= loss_q;
			out_def_q  <= defer_q;
			out_rhoi_q <= rhoi_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q       <= REF_RTT_RST;
			clamp_q     <= CLAMP_MAX;
			cwnd_q      <= '0;
			credit_q    <= '0;
			stall_q     <= '0;
			rho8_q      <= '0;
			rhoi_q      <= '0;
			rho_sq_q    <= '0;
			min_q       <= '1;
			enh_q       <= 1'b1;
			inc_q       <= '0;
			slow_q      <= 1'b0;
			carry_q     <= 1'b0;
			defer_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_REF_RTT: ref_q   <= cfg_data[REF_W-1:0];
					CFG_CLAMP:   clamp_q <= cfg_data[CLAMP_W-1:0];
					default:     ref_q   <= ref_q;
				endcase
			end

			if (cmd.upd_min)
				min_q <= rtt_q;

			if (cmd.act == ACT_OUT)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (cmd.act)
				ACT_LOAD: defer_q <= 1'b0;
				ACT_RHO_SET: begin
					rho8_q   <= rho_new;
					rhoi_q   <= rho_new[RTT_W-1:3];
					rho_sq_q <= {rho_prod[WIN_W-2:0], 1'b0};
				end
				ACT_INIT: begin
					credit_q <= '0;
					enh_q    <= 1'b1;
					clamp_q  <= CLAMP_MAX;
					cwnd_q   <= {{(WIN_W-RHOI_W){1'b0}}, rhoi_q};
				end
				ACT_STATE: enh_q   <= open_q;
				ACT_WIN:   cwnd_q  <= {{(WIN_W-NWIN_W){1'b0}}, nwin_q};
				ACT_DEFER: defer_q <= 1'b1;
				ACT_SLOW_INC: begin
					inc_q  <= slow_inc;
					slow_q <= 1'b1;
				end
				ACT_DIV_INC: begin
					inc_q  <= div_quo;
					slow_q <= 1'b0;
					// below one whole unit counts as a stalled ack
					if (div_quo < WIN_W'(128))
						stall_q <= stall_q + WIN_W'(1);
				end
				ACT_ADD: begin
					cwnd_q   <= cwnd_q + {{CRED_W{1'b0}}, inc_q[WIN_W-1:CRED_W]};
					credit_q <= credit_sum[CRED_W-1:0];
					carry_q  <= credit_sum[CRED_W];
				end
				ACT_CARRY: begin
					if (carry_q) begin
						cwnd_q  <= cwnd_q + WIN_W'(1);
						stall_q <= '0;
					end
				end
				ACT_STALL: begin
					// force growth on a zero increment once the stall count reaches the window
					if (inc_q == '0 && stall_q >= cwnd_q) begin
						cwnd_q  <= cwnd_q + WIN_W'(1);
						stall_q <= '0;
					end
				end
				ACT_CLAMP_SS: begin
					if (slow_q && cwnd_q > {1'b0, ssth_q})
						cwnd_q <= {1'b0, ssth_q};
				end
				ACT_CLAMP_WIN: begin
					if (cwnd_q > {{(WIN_W-CLAMP_W){1'b0}}, clamp_q})
						cwnd_q <= {{(WIN_W-CLAMP_W){1'b0}}, clamp_q};
				end
				default: carry_q <= carry_q;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign window         = out_win_q;
	assign loss_threshold = out_loss_q;
	assign deferred       = out_def_q;
	assign rho_integer    = out_rhoi_q;

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.act == ACT_OUT |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while held");

	a_clamp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.act == ACT_CLAMP_WIN |=> cwnd_q <= {{(WIN_W-CLAMP_W){1'b0}}, clamp_q})
		else $error("window above clamp after clamping");

	a_loss_floor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.act == ACT_LOSS2 |=> loss_q >= WIN_W'(2))
		else $error("loss threshold below two");

endmodule
`default_nettype wire

### hdl/hybla_style_cwnd_update.sv
// Top level of the Hybla-style congestion window update engine.
// Each request runs from accept to result valid through the sequencer states; the divider
// sets the span for init and for acks (two divisions for an ack that sees a new minimum RTT
// and grows in avoidance); out_stall holding a result adds to the span.
// Throughput: one request at a time; the next request is accepted once the result is in
// the output register, so a held result does not block intake of the next request.
// Reset (arst_n low, asynchronous): all window state returns to its reset values at once.
`default_nettype none
module hybla_style_cwnd_update
	import hscu_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// request channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           op,
	input  wire logic [RTT_W-1:0]     smoothed_rtt,
	input  wire logic                 window_limited,
	input  wire logic                 state_open,
	input  wire logic [SSTH_W-1:0]    slow_start_threshold,
	input  wire logic [NWIN_W-1:0]    new_window,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [WIN_W-1:0]          window,
	output logic [WIN_W-1:0]          loss_threshold,
	output logic                      deferred,
	output logic [RHOI_W-1:0]         rho_integer,
	// configuration write port
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	// The sequencer walks each request through decode, optional rho recompute
	// (RTT over reference RTT on the divider, then one squaring), for growing acks the
	// increment, credit carry, stall push and the two clamps, and then the loss threshold.
	cmd_t  cmd;
	stat_t stat;

	hscu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Hold all state, the divider and the result register; drop nothing
	// while the downstream side stalls.
	hscu_dp u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.stat                 (stat),
		.op                   (op),
		.smoothed_rtt         (smoothed_rtt),
		.window_limited       (window_limited),
		.state_open           (state_open),
		.slow_start_threshold (slow_start_threshold),
		.new_window           (new_window),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.window               (window),
		.loss_threshold       (loss_threshold),
		.deferred             (deferred),
		.rho_integer          (rho_integer)
	);

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the Hybla-style congestion window update engine.
module testbench
	import hscu_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// One request as the sender sees it, with every field at the port width.
	typedef struct {
		op_t               op;
		logic [RTT_W-1:0]  rtt;
		logic              limited;
		logic              open;
		logic [SSTH_W-1:0] ssth;
		logic [NWIN_W-1:0] nwin;
	} cwnd_request_t;

	// One result of the block: window, loss threshold, fallback flag and rho.
	typedef struct {
		logic [WIN_W-1:0]  window;
		logic [WIN_W-1:0]  loss;
		logic              deferred;
		logic [RHOI_W-1:0] rho_int;
	} window_report_t;

	// Cycles to let pass after the last result before a register write; the
	// slowest ack runs two divider passes plus its control states.
	localparam int DRAIN_CYCLES = 90;
	localparam int unsigned SSTH_ALL = 32'h7FFF_FFFF;
	// Init with this rtt times the reference gives rho of 8192: its square wraps to
	// zero, so acks in avoidance add nothing and only the stall counter grows the window.
	localparam int unsigned RHO_WRAP_TICKS = 65536;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           op;
	logic [RTT_W-1:0]     smoothed_rtt;
	logic                 window_limited;
	logic                 state_open;
	logic [SSTH_W-1:0]    slow_start_threshold;
	logic [NWIN_W-1:0]    new_window;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [WIN_W-1:0]     window;
	logic [WIN_W-1:0]     loss_threshold;
	logic                 deferred;
	logic [RHOI_W-1:0]    rho_integer;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	// Suppress idling on both sides while set.
	bit quiet = 1'b0;
	int mismatch_count = 0;
	window_report_t expected_reports[$];

	// Window state tracked alongside the block.
	logic [REF_W-1:0]   m_ref_rtt;
	logic [CLAMP_W-1:0] m_clamp;
	logic [31:0]        m_cwnd;
	logic [CRED_W-1:0]  m_credit;
	logic [31:0]        m_stall;
	logic [31:0]        m_rho8;
	logic [28:0]        m_rho_int;
	logic [31:0]        m_rho_sq;
	logic [RTT_W-1:0]   m_min_rtt;
	logic               m_enhanced;

	hybla_style_cwnd_update dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.op                  (op),
		.smoothed_rtt        (smoothed_rtt),
		.window_limited      (window_limited),
		.state_open          (state_open),
		.slow_start_threshold(slow_start_threshold),
		.new_window          (new_window),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.window              (window),
		.loss_threshold      (loss_threshold),
		.deferred            (deferred),
		.rho_integer         (rho_integer),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Window predictor
	// ------------------------------------------------------------------

	// 2^(f/8) in 1/128 units.
	function automatic logic [7:0] frac_gain(input logic [2:0] f);
		case (f)
			3'd0: return 8'd128;
			3'd1: return 8'd139;
			3'd2: return 8'd152;
			3'd3: return 8'd165;
			3'd4: return 8'd181;
			3'd5: return 8'd197;
			3'd6: return 8'd215;
			default: return 8'd234;
		endcase
	endfunction

	function automatic int unsigned ref_ticks();
		return (m_ref_rtt == '0) ? 1 : {22'd0, m_ref_rtt};
	endfunction

	function automatic void reset_window_model();
		m_ref_rtt  = REF_RTT_RST;
		m_clamp    = CLAMP_MAX;
		m_cwnd     = '0;
		m_credit   = '0;
		m_stall    = '0;
		m_rho8     = '0;
		m_rho_int  = '0;
		m_rho_sq   = '0;
		m_min_rtt  = '1;
		m_enhanced = 1'b1;
	endfunction

	// Rho in eighths is rtt over the reference, floored at one; a zero
	// reference divides as one.
	function automatic void recompute_rho(input logic [RTT_W-1:0] rtt);
		logic [31:0] divisor;
		logic [31:0] ratio;
		logic [63:0] square;
		divisor = (m_ref_rtt == '0) ? 32'd1 : {22'd0, m_ref_rtt};
		ratio = {8'd0, rtt} / divisor;
		if (ratio < 32'd8)
			ratio = 32'd8;
		m_rho8 = ratio;
		m_rho_int = ratio[31:3];
		square = {32'd0, ratio} * {32'd0, ratio};
		m_rho_sq = {square[30:0], 1'b0};
	endfunction

	function automatic logic [31:0] loss_threshold_of(input logic [31:0] c);
		logic [63:0] sum;
		sum = {32'd0, c} - {33'd0, c[31:1]} + {34'd0, c[31:2]} + {35'd0, c[31:3]}
			+ {37'd0, c[31:5]};
		if (sum[31:0] < 32'd2)
			return 32'd2;
		return sum[31:0];
	endfunction

	// Advance the window for one ack; return the fallback flag.
	function automatic logic process_ack(input logic [RTT_W-1:0] rtt, input logic limited,
			input logic [SSTH_W-1:0] ssth);
		logic [31:0] inc;
		logic [31:0] divisor;
		logic [4:0]  shift;
		logic [7:0]  credit_sum;
		logic        slow;
		if (rtt < m_min_rtt) begin
			recompute_rho(rtt);
			m_min_rtt = rtt;
		end
		if (!limited)
			return 1'b0;
		if (!m_enhanced)
			return 1'b1;
		if (m_rho_int == '0)
			recompute_rho(rtt);
		slow = m_cwnd < {1'b0, ssth};
		if (slow) begin
			shift = (m_rho_int < 29'd16) ? m_rho_int[4:0] : 5'd16;
			inc = (32'd1 << shift) * {24'd0, frac_gain(m_rho8[2:0])} - 32'd128;
		end else begin
			divisor = (m_cwnd == '0) ? 32'd1 : m_cwnd;
			inc = m_rho_sq / divisor;
			if (inc < 32'd128)
				m_stall = m_stall + 32'd1;
		end
		m_cwnd = m_cwnd + {7'd0, inc[31:7]};
		credit_sum = {1'b0, m_credit} + {1'b0, inc[6:0]};
		if (credit_sum >= 8'd128) begin
			m_cwnd = m_cwnd + 32'd1;
			credit_sum = credit_sum - 8'd128;
			m_stall = '0;
		end
		m_credit = credit_sum[6:0];
		if (inc == '0 && m_stall >= m_cwnd) begin
			m_cwnd = m_cwnd + 32'd1;
			m_stall = '0;
		end
		if (slow && m_cwnd > {1'b0, ssth})
			m_cwnd = {1'b0, ssth};
		if (m_cwnd > {16'd0, m_clamp})
			m_cwnd = {16'd0, m_clamp};
		return 1'b0;
	endfunction

	function automatic window_report_t apply_request(input cwnd_request_t r);
		window_report_t rep;
		logic           flag;
		flag = 1'b0;
		case (r.op)
			OP_ACK: flag = process_ack(r.rtt, r.limited, r.ssth);
			OP_INIT: begin
				m_credit = '0;
				m_enhanced = 1'b1;
				m_clamp = CLAMP_MAX;
				recompute_rho(r.rtt);
				m_min_rtt = r.rtt;
				m_cwnd = {3'd0, m_rho_int};
			end
			OP_STATE: m_enhanced = r.open;
			default: m_cwnd = {16'd0, r.nwin};
		endcase
		rep.window = m_cwnd;
		rep.loss = loss_threshold_of(m_cwnd);
		rep.deferred = flag;
		rep.rho_int = m_rho_int[RHOI_W-1:0];
		return rep;
	endfunction

	// ------------------------------------------------------------------
	// Request builders: fields the op ignores carry random values
	// ------------------------------------------------------------------

	function automatic cwnd_request_t random_request();
		cwnd_request_t r;
		logic [31:0]   w;
		w = $urandom;
		r.op = op_t'(w[1:0]);
		r.limited = w[8];
		r.open = w[9];
		w = $urandom;
		r.rtt = w[RTT_W-1:0];
		w = $urandom;
		r.ssth = w[SSTH_W-1:0];
		w = $urandom;
		r.nwin = w[NWIN_W-1:0];
		return r;
	endfunction

	function automatic cwnd_request_t ack_request(input int unsigned rtt, input logic limited,
			input int unsigned ssth);
		cwnd_request_t r;
		r = random_request();
		r.op = OP_ACK;
		r.rtt = rtt[RTT_W-1:0];
		r.limited = limited;
		r.ssth = ssth[SSTH_W-1:0];
		return r;
	endfunction

	function automatic cwnd_request_t init_request(input int unsigned rtt);
		cwnd_request_t r;
		r = random_request();
		r.op = OP_INIT;
		r.rtt = rtt[RTT_W-1:0];
		return r;
	endfunction

	function automatic cwnd_request_t state_request(input logic open);
		cwnd_request_t r;
		r = random_request();
		r.op = OP_STATE;
		r.open = open;
		return r;
	endfunction

	function automatic cwnd_request_t window_request(input int unsigned nwin);
		cwnd_request_t r;
		r = random_request();
		r.op = OP_WIN;
		r.nwin = nwin[NWIN_W-1:0];
		return r;
	endfunction

	// Ack rtt: mostly at or a little above the current minimum, so rho stays put;
	// now and then below it, which recomputes rho.
	function automatic int unsigned follow_rtt();
		int unsigned v;
		if ($urandom_range(0, 9) == 0)
			v = $urandom_range(0, {8'd0, m_min_rtt});
		else
			v = {8'd0, m_min_rtt} + $urandom_range(0, 8 * ref_ticks());
		if (v > 32'h00FF_FFFF)
			v = 32'h00FF_FFFF;
		return v;
	endfunction

	// Threshold near zero, near the window (both phases), mid range, or anything.
	function automatic int unsigned pick_ssth();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 35)
			return $urandom_range(0, 64);
		if (sel < 70)
			return (m_cwnd > 32'd32) ? m_cwnd - 32 + $urandom_range(0, 64) : $urandom_range(0, 64);
		if (sel < 90)
			return $urandom_range(1000, 70000);
		return $urandom & SSTH_ALL;
	endfunction

	// ------------------------------------------------------------------
	// Request and configuration drivers
	// ------------------------------------------------------------------

	// Present one request, hold it through stall, and predict its result once
	// it is taken. Valid stays high afterwards so back-to-back requests need
	// no second assignment in the same step.
	task automatic send_request(input cwnd_request_t r);
		if (!quiet && $urandom_range(0, 99) < 12) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid             <= 1'b1;
		op                   <= r.op;
		smoothed_rtt         <= r.rtt;
		window_limited       <= r.limited;
		state_open           <= r.open;
		slow_start_threshold <= r.ssth;
		new_window           <= r.nwin;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		expected_reports.push_back(apply_request(r));
	endtask

	// Drop valid, wait out every pending result, then let the block settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_REF_RTT)
			m_ref_rtt = data[REF_W-1:0];
		else
			m_clamp = data;
		@(posedge clk);
	endtask

	// Mostly growth runs (init or window load, then a string of acks), with
	// bursts of noise and, where init is allowed, stall-driven growth.
	task automatic run_traffic(input int count, input int init_pct);
		int          sent;
		int          kind;
		int          len;
		int          i;
		int unsigned rtt;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 10) begin
				len = $urandom_range(1, 4);
				for (i = 0; i < len; i++)
					send_request(random_request());
				sent += len;
			end else if (kind < 20 && init_pct > 0 && ref_ticks() <= 255) begin
				rtt = RHO_WRAP_TICKS * ref_ticks();
				send_request(init_request(rtt));
				send_request(window_request($urandom_range(0, 6)));
				len = $urandom_range(3, 12);
				for (i = 0; i < len; i++)
					send_request(ack_request(rtt, 1'b1, 0));
				sent += len + 2;
			end else begin
				if ($urandom_range(0, 99) < init_pct) begin
					rtt = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 64 * ref_ticks())
						: ($urandom & 32'h00FF_FFFF);
					send_request(init_request(rtt));
				end else begin
					send_request(window_request($urandom_range(0, 64)));
				end
				len = $urandom_range(4, 30);
				for (i = 0; i < len; i++) begin
					if ($urandom_range(0, 19) == 0)
						send_request(state_request($urandom_range(0, 3) != 0));
					else
						send_request(ack_request(follow_rtt(), $urandom_range(0, 9) != 0,
							pick_ssth()));
				end
				sent += len + 1;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Field extremes, every op and each corner case, under reset settings.
	task automatic test_directed();
		// Ack before any init at the largest rtt: rho is still zero, so the ack
		// derives it on the spot; a zero threshold puts a zero window in avoidance.
		send_request(ack_request(32'h00FF_FFFF, 1'b1, 0));
		send_request(init_request(40));
		send_request(ack_request(40, 1'b1, SSTH_ALL));
		send_request(ack_request(60, 1'b0, SSTH_ALL));
		// Not open: a window-limited ack raises the fallback flag, others do not.
		send_request(state_request(1'b0));
		send_request(ack_request(60, 1'b1, SSTH_ALL));
		send_request(ack_request(60, 1'b0, SSTH_ALL));
		send_request(state_request(1'b1));
		// Largest rtt on init: huge window, not clamped by init.
		send_request(init_request(32'h00FF_FFFF));
		// Rho of 3 and 5/8 in slow start, then the clamp bites.
		send_request(ack_request(145, 1'b1, SSTH_ALL));
		send_request(ack_request(0, 1'b1, 0));
		// Zero window loaded from outside, then an avoidance ack on it.
		send_request(window_request(0));
		send_request(ack_request(0, 1'b1, 0));
		send_request(window_request(16'hFFFF));
		send_request(ack_request(0, 1'b1, 0));
		// Squared rho wraps to zero: growth comes from the stall counter alone.
		send_request(init_request(RHO_WRAP_TICKS * 5));
		send_request(window_request(2));
		repeat (3) send_request(ack_request(RHO_WRAP_TICKS * 5, 1'b1, 0));
		// Slow start with the shift capped at 16, cut back to the threshold.
		send_request(window_request(10));
		send_request(ack_request(RHO_WRAP_TICKS * 5, 1'b1, 20));
		send_request(ack_request(RHO_WRAP_TICKS * 5, 1'b1, SSTH_ALL));
	endtask

	// Reference rtt at one, at 1000, at zero (divides as one) and with every
	// data bit set (only the low ten bits land).
	task automatic test_reference_rtt_sweep();
		logic [CFG_DAT_W-1:0] settings[4];
		settings = '{16'd1, 16'd1000, 16'd0, 16'hFFFF};
		foreach (settings[i]) begin
			wait_idle();
			write_register(CFG_REF_RTT, settings[i]);
			run_traffic(110, 30);
		end
	endtask

	// Init restores the clamp to its maximum, so these runs plan no init; only noise bursts can still send one.
	task automatic test_window_clamp();
		logic [CFG_DAT_W-1:0] settings[4];
		logic [31:0]          w;
		w = $urandom;
		settings = '{16'd1, 16'd300, w[15:0], 16'hFFFF};
		wait_idle();
		write_register(CFG_REF_RTT, CFG_DAT_W'($urandom_range(1, 1000)));
		foreach (settings[i]) begin
			wait_idle();
			write_register(CFG_CLAMP, settings[i]);
			run_traffic(80, 0);
		end
	endtask

	// Random settings; first half with no idling on either side.
	task automatic test_mixed_settings();
		wait_idle();
		write_register(CFG_CLAMP, CFG_DAT_W'($urandom_range(1, 65535)));
		write_register(CFG_REF_RTT, CFG_DAT_W'($urandom_range(1, 1000)));
		quiet = 1'b1;
		run_traffic(150, 30);
		quiet = 1'b0;
		run_traffic(150, 30);
	endtask

	task automatic test_noise();
		int i;
		for (i = 0; i < 60; i++)
			send_request(random_request());
	endtask

	// ------------------------------------------------------------------
	// Result checking and receiver stall
	// ------------------------------------------------------------------

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Check every taken result against the oldest prediction, then pick the
	// stall for the next edge.
	always @(posedge clk) begin
		window_report_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual window %0d",
					$time, window);
				mismatch_count++;
			end else begin
				want = expected_reports.pop_front();
				compare_field("window", want.window, window);
				compare_field("loss_threshold", want.loss, loss_threshold);
				compare_field("deferred", {31'd0, want.deferred}, {31'd0, deferred});
				compare_field("rho_integer", {11'd0, want.rho_int}, {11'd0, rho_integer});
			end
		end
		out_stall <= !quiet && ($urandom_range(0, 99) < 12);
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n               = 1'b0;
		in_valid             = 1'b0;
		op                   = OP_ACK;
		smoothed_rtt         = '0;
		window_limited       = 1'b0;
		state_open           = 1'b0;
		slow_start_threshold = '0;
		new_window           = '0;
		cfg_we               = 1'b0;
		cfg_index            = CFG_REF_RTT;
		cfg_data             = '0;
		reset_window_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_reference_rtt_sweep();
		test_window_clamp();
		test_mixed_settings();
		test_noise();
		wait_idle();

		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Hang guard: the slowest correct run needs a fraction of this.
	initial begin
		#8_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
